### rtl/crv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crv_pkg
// Shared sizes, command codes and types for the curve resampler.
// ----------------------------------------------------------------------------
package crv_pkg;

  localparam int SAMPLES = 64;
  localparam int SPAN    = SAMPLES - 1;
  localparam int IDX_W   = $clog2(SAMPLES);
  localparam int XP_W    = 16 + IDX_W;          // x * span, unsigned
  localparam int DX_W    = XP_W + 1;            // grid x minus segment end
  localparam int DY_W    = 18;                  // y0 - y1
  localparam int NUM_W   = DX_W + DY_W;
  localparam int DEN_W   = 17 + IDX_W;
  localparam int NW      = NUM_W + 2;           // rounded dividend
  localparam int DV_W    = DEN_W + 1;           // divisor 2*|den|
  localparam int REM_W   = DEN_W + 2;
  localparam int CNT_W   = $clog2(NW + 1);
  localparam int SW      = NW + 2;              // width handed to saturation

  typedef logic [1:0] op_t;
  localparam op_t OP_QUERY = 2'd0;
  localparam op_t OP_INVAL = 2'd1;
  localparam op_t OP_BUILD = 2'd2;

  typedef struct packed {
    op_t         op;
    logic [15:0] qx;
  } cmd_t;

  typedef struct packed {
    logic [15:0]        x;
    logic signed [16:0] y;
  } point_t;

  localparam int PT_W = $bits(point_t);

  typedef struct packed {
    logic build_done;
    logic busy;
  } bk_stat_t;

  function automatic logic signed [16:0] sat17(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi;
    lo = -(SW'(65536));
    hi = SW'(65535);
    if (v < lo) sat17 = 17'sh10000;
    else if (v > hi) sat17 = 17'sh0FFFF;
    else sat17 = v[16:0];
  endfunction

endpackage
`default_nettype wire

### rtl/curve_resample_interpolator_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// curve_resample_interpolator_unit
// Loads curve points, resamples them onto a uniform grid, answers queries.
// ----------------------------------------------------------------------------
//  channel   handshake            payload
//  input     push / full          mode, sample_x, sample_y, query_x
//  result    pop / empty          value, table_ready
//
//  A load yields no result. A query passes the back end in steps (command
//  pop, grid read, capture and multiply, round, output register); with no
//  table it goes from the command pop straight to the output register.
//  The last load of a set starts the table build: command pop and the
//  fetch of the first segment, then per grid point a segment step (walk
//  and advance) as often as needed, a walk check, a multiply, a set-up, a
//  restoring divide (skipped for a vertical segment) and a write; full
//  stays high from the last load until the build is done.
//  Full also rises while the four-entry command queue is full.
//  Reset is synchronous and clears the point count and the table flag.
//  A result waits in the output register; the back end stalls on it alone.
// ----------------------------------------------------------------------------
module curve_resample_interpolator_unit import crv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output      logic               full,
  input  wire logic               mode,
  input  wire logic [15:0]        sample_x,
  input  wire logic signed [16:0] sample_y,
  input  wire logic [15:0]        query_x,
  output      logic               empty,
  input  wire logic               pop,
  output      logic signed [16:0] value,
  output      logic               table_ready
);

  cmd_t             q_in, q_out;
  logic             q_push, q_full, q_pop, q_empty;
  logic             pt_we;
  logic [IDX_W-1:0] pt_waddr, pt_raddr;
  point_t           pt_wdata;
  logic [PT_W-1:0]  pt_rdata;
  bk_stat_t         stat;

  // front end: accepts transactions and writes the point store
  crv_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .sample_x(sample_x), .sample_y(sample_y), .query_x(query_x),
    .q_data(q_in), .q_push(q_push), .q_full(q_full),
    .pt_we(pt_we), .pt_waddr(pt_waddr), .pt_wdata(pt_wdata), .stat(stat)
  );

  // point store, stable while a build reads it
  crv_ram #(.WIDTH(PT_W), .DEPTH(SAMPLES)) u_points (
    .clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
    .raddr(pt_raddr), .rdata(pt_rdata)
  );

  crv_cmd_queue u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_in), .full(q_full),
    .pop(q_pop), .rdata(q_out), .empty(q_empty)
  );

  // back end: build and query execution, output register
  crv_back u_back (
    .clk(clk), .rst(rst), .cmd(q_out), .cmd_empty(q_empty), .cmd_pop(q_pop),
    .pt_raddr(pt_raddr), .pt_rdata(point_t'(pt_rdata)),
    .empty(empty), .pop(pop), .value(value), .table_ready(table_ready),
    .stat(stat)
  );

  // no input transaction while the table is being built
  a_build_blocks: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> full)
    else $error("input open during table build");

  // a result without a table carries zero
  a_zero_unready: assert property (@(posedge clk) disable iff (rst)
    (!empty && !table_ready) |-> (value == 17'sd0))
    else $error("non-zero value without table");

  // a finished build releases the front end
  a_done_release: assert property (@(posedge clk) disable iff (rst)
    stat.build_done |-> !stat.busy)
    else $error("build done while still busy");

endmodule
`default_nettype wire

### rtl/crv_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crv_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module crv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/crv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crv_front
// Takes input transactions, stores curve points, issues commands.
// ----------------------------------------------------------------------------
module crv_front import crv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output      logic               full,
  input  wire logic               mode,
  input  wire logic [15:0]        sample_x,
  input  wire logic signed [16:0] sample_y,
  input  wire logic [15:0]        query_x,
  output      cmd_t               q_data,
  output      logic               q_push,
  input  wire logic               q_full,
  output      logic               pt_we,
  output      logic [IDX_W-1:0]   pt_waddr,
  output      point_t             pt_wdata,
  input  wire bk_stat_t           stat
);

  logic [IDX_W-1:0] load_count;
  logic             waiting;
  logic             acc;
  logic             first;
  logic             last;

  assign full  = waiting | q_full;
  assign acc   = push & ~full;
  assign first = (load_count == '0);
  assign last  = (load_count == IDX_W'(SPAN));

  assign q_push    = acc & (mode | first | last);
  assign q_data.op = mode ? OP_QUERY : (last ? OP_BUILD : OP_INVAL);
  assign q_data.qx = query_x;

  assign pt_we      = acc & ~mode;
  assign pt_waddr   = load_count;
  assign pt_wdata.x = sample_x;
  assign pt_wdata.y = sample_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
      waiting    <= 1'b0;
    end else begin
      if (acc && !mode) begin
        load_count <= last ? '0 : load_count + 1'b1;
        if (last) waiting <= 1'b1;
      end
      if (stat.build_done) waiting <= 1'b0;
    end
  end

endmodule
`default_nettype wire

### rtl/crv_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crv_cmd_queue
// Four-entry command queue between front and back.
// ----------------------------------------------------------------------------
module crv_cmd_queue import crv_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wdata,
  output      logic full,
  input  wire logic pop,
  output      cmd_t rdata,
  output      logic empty
);

  cmd_t       buf_q [4];
  logic [1:0] wp;
  logic [1:0] rp;
  logic [2:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 3'd4);
  assign empty   = (cnt == 3'd0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = buf_q[rp];

  always_ff @(posedge clk) begin
    if (do_push) buf_q[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= wp + 1'b1;
      if (do_pop) rp <= rp + 1'b1;
      cnt <= cnt + {2'b0, do_push} - {2'b0, do_pop};
    end
  end

endmodule
`default_nettype wire

### rtl/crv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crv_back
// Executes commands: table build with a serial divider, table invalidation, and queries.
// ----------------------------------------------------------------------------
module crv_back import crv_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cmd_t               cmd,
  input  wire logic               cmd_empty,
  output      logic               cmd_pop,
  output      logic [IDX_W-1:0]   pt_raddr,
  input  wire point_t             pt_rdata,
  output      logic               empty,
  input  wire logic               pop,
  output      logic signed [16:0] value,
  output      logic               table_ready,
  output      bk_stat_t           stat
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_CAP1 = 4'd3;
  localparam logic [3:0] S_WALK = 4'd4;
  localparam logic [3:0] S_ADV  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_PREP = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_QA   = 4'd10;
  localparam logic [3:0] S_QB   = 4'd11;
  localparam logic [3:0] S_QOUT = 4'd12;
  localparam logic [3:0] S_QW   = 4'd13;

  localparam logic signed [DEN_W-1:0] SPAN_S = DEN_W'(SPAN);

  logic [3:0]               state;
  logic                     ready_flag;
  logic                     out_valid;
  logic                     build_done;

  // build registers
  logic [15:0]              x0, x1;
  logic signed [16:0]       y0, y1;
  logic [IDX_W:0]           next;
  logic [IDX_W-1:0]         k;
  logic signed [NUM_W-1:0]  num;
  logic signed [DEN_W-1:0]  den;
  logic                     den_zero;
  logic                     neg;
  logic [REM_W-1:0]         rem;
  logic [NW-1:0]            quo;
  logic [DV_W-1:0]          dvs;
  logic [CNT_W-1:0]         dcnt;

  // query registers
  logic [IDX_W-1:0]         qa, qb;
  logic [14:0]              frac;
  logic signed [16:0]       t0;
  logic signed [33:0]       prod;
  logic signed [16:0]       qv;
  logic                     qtr;

  // grid table, two copies for the two query reads
  logic                     g_we;
  logic signed [16:0]       g_wdata;
  logic [16:0]              rd_a, rd_b;

  // combinational helpers
  logic [XP_W-1:0]          xs, x1sp;
  logic [XP_W-1:0]          qscaled;
  logic [XP_W-16:0]         qidx;
  logic signed [NW-1:0]     nn, dd, nn2, dd2, nbig;
  logic [REM_W-1:0]         shifted;
  logic signed [NW:0]       qsig;
  logic signed [SW-1:0]     bsum;
  logic signed [SW-1:0]     qsum;
  logic signed [DX_W-1:0]   dx;
  logic signed [DY_W-1:0]   dy;
  logic signed [16:0]       dxp;
  logic signed [17:0]       dt;

  assign xs      = XP_W'({k, 15'b0});
  assign x1sp    = XP_W'(x1 * SPAN);
  assign qscaled = XP_W'(cmd.qx * SPAN);
  assign qidx    = qscaled[XP_W-1:15];
  assign dx      = $signed({1'b0, xs}) - $signed({1'b0, x1sp});
  assign dy      = DY_W'(y0) - DY_W'(y1);
  assign dxp     = $signed({1'b0, x0}) - $signed({1'b0, x1});

  assign nn   = NW'(num);
  assign dd   = NW'(den);
  assign nn2  = dd[NW-1] ? -nn : nn;
  assign dd2  = dd[NW-1] ? -dd : dd;
  assign nbig = (nn2 <<< 1) + dd2;

  assign shifted = {rem[REM_W-2:0], quo[NW-1]};
  assign qsig    = neg ? ~$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign bsum    = SW'(y1) + SW'(qsig);
  assign qsum    = SW'(t0) + SW'((prod + 34'sd16384) >>> 15);
  assign dt      = 18'(signed'(rd_b)) - 18'(signed'(rd_a));

  assign g_we    = (state == S_FIN);
  assign g_wdata = den_zero ? y1 : sat17(bsum);

  crv_ram #(.WIDTH(17), .DEPTH(SAMPLES)) u_grid_a (
    .clk(clk), .we(g_we), .waddr(k), .wdata(g_wdata), .raddr(qa), .rdata(rd_a)
  );

  crv_ram #(.WIDTH(17), .DEPTH(SAMPLES)) u_grid_b (
    .clk(clk), .we(g_we), .waddr(k), .wdata(g_wdata), .raddr(qb), .rdata(rd_b)
  );

  always_comb begin
    pt_raddr = '0;
    case (state)
      S_RD0:   pt_raddr = '0;
      S_RD1:   pt_raddr = IDX_W'(1);
      S_WALK:  pt_raddr = next[IDX_W-1:0];
      default: pt_raddr = '0;
    endcase
  end

  assign cmd_pop         = (state == S_IDLE) & ~cmd_empty;
  assign empty           = ~out_valid;
  assign stat.busy       = (state != S_IDLE) & (state != S_QW) & (state != S_QA)
                           & (state != S_QB) & (state != S_QOUT);
  assign stat.build_done = build_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ready_flag <= 1'b0;
      out_valid  <= 1'b0;
      build_done <= 1'b0;
    end else begin
      build_done <= 1'b0;
      if (pop && out_valid) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            case (cmd.op)
              OP_INVAL: ready_flag <= 1'b0;
              OP_BUILD: state <= S_RD0;
              OP_QUERY: state <= ready_flag ? S_QW : S_QOUT;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_CAP1;
        S_CAP1: state <= S_WALK;
        S_WALK: state <= ((xs > x1sp) && (next < (IDX_W+1)'(SAMPLES))) ? S_ADV : S_MUL;
        S_ADV:  state <= S_WALK;
        S_MUL:  state <= S_PREP;
        S_PREP: state <= (den == '0) ? S_FIN : S_DIV;
        S_DIV:  if (dcnt == CNT_W'(1)) state <= S_FIN;
        S_FIN: begin
          if (k == IDX_W'(SPAN)) begin
            state      <= S_IDLE;
            ready_flag <= 1'b1;
            build_done <= 1'b1;
          end else begin
            state <= S_WALK;
          end
        end
        S_QW:   state <= S_QA;
        S_QA:   state <= S_QB;
        S_QB:   state <= S_QOUT;
        S_QOUT: begin
          if (!out_valid || pop) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        qtr <= ready_flag;
        qv  <= '0;
        k   <= '0;
        if (qidx >= (XP_W-15)'(SPAN)) begin
          qa   <= IDX_W'(SPAN);
          qb   <= IDX_W'(SPAN);
          frac <= '0;
        end else begin
          qa   <= qidx[IDX_W-1:0];
          qb   <= qidx[IDX_W-1:0] + 1'b1;
          frac <= qscaled[14:0];
        end
      end
      S_RD1: begin
        x0 <= pt_rdata.x;
        y0 <= pt_rdata.y;
      end
      S_CAP1: begin
        x1   <= pt_rdata.x;
        y1   <= pt_rdata.y;
        next <= (IDX_W+1)'(2);
      end
      S_ADV: begin
        x0   <= x1;
        y0   <= y1;
        x1   <= pt_rdata.x;
        y1   <= pt_rdata.y;
        next <= next + 1'b1;
      end
      S_MUL: begin
        num <= NUM_W'(dy) * NUM_W'(dx);
        den <= DEN_W'(dxp) * SPAN_S;
      end
      S_PREP: begin
        den_zero <= (den == '0);
        neg      <= nbig[NW-1];
        quo      <= nbig[NW-1] ? ~nbig : nbig;
        rem      <= '0;
        dvs      <= DV_W'(dd2 <<< 1);
        dcnt     <= CNT_W'(NW);
      end
      S_DIV: begin
        dcnt <= dcnt - 1'b1;
        if (shifted >= {1'b0, dvs}) begin
          rem <= shifted - {1'b0, dvs};
          quo <= {quo[NW-2:0], 1'b1};
        end else begin
          rem <= shifted;
          quo <= {quo[NW-2:0], 1'b0};
        end
      end
      S_FIN: k <= k + 1'b1;
      S_QA: begin
        t0   <= signed'(rd_a);
        prod <= 34'(dt) * 34'(signed'({1'b0, frac}));
      end
      S_QB: qv <= sat17(qsum);
      S_QOUT: begin
        if (!out_valid || pop) begin
          value       <= qv;
          table_ready <= qtr;
        end
      end
      default: ;
    endcase
    if (state == S_FIN) den_zero <= 1'b0;
  end

endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the curve resampler: loads point sets, lets the
// table build, then queries it; every result is checked against a local
// fixed point predictor of the table build and the query interpolation.
// ----------------------------------------------------------------------------
module tb_top import crv_pkg::*;;

  localparam bit MODE_LOAD  = 1'b0;
  localparam bit MODE_QUERY = 1'b1;

  typedef struct {
    bit          mode;
    logic [15:0] sx;
    logic [16:0] sy;
    logic [15:0] qx;
  } txn_t;

  typedef struct {
    logic [16:0] value;
    logic        table_ready;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic mode = 1'b0;
  logic [15:0] sample_x = '0;
  logic signed [16:0] sample_y = '0;
  logic [15:0] query_x = '0;
  logic pop = 1'b0;
  logic full, empty, table_ready;
  logic signed [16:0] value;

  txn_t    pending_q[$];
  answer_t answer_q[$];
  int      errors = 0;
  bit      stim_done = 1'b0;

  // predictor state
  longint pt_x[SAMPLES];
  longint pt_y[SAMPLES];
  longint grid[SAMPLES];
  int     n_loaded = 0;
  bit     built = 1'b0;

  // handshake state captured at the rising edge
  txn_t cur_t;
  logic full_s = 1'b1;
  logic empty_s = 1'b1;
  int   gap_in = 0;
  int   gap_out = 0;

  curve_resample_interpolator_unit DUT (
    .clk(clk), .rst(rst), .push(push), .full(full), .mode(mode),
    .sample_x(sample_x), .sample_y(sample_y), .query_x(query_x),
    .empty(empty), .pop(pop), .value(value), .table_ready(table_ready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void add_pending(txn_t t);
    pending_q = {pending_q, t};
  endfunction

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q -= 1;
    return q;
  endfunction

  function automatic longint rdiv(longint n, longint d);
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    return fdiv(2 * n + d, 2 * d);
  endfunction

  function automatic longint clip17(longint v);
    if (v < -65536) return -65536;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // Resample the loaded points onto the uniform grid, forward segment walk.
  function automatic void resample_grid();
    longint x0, y0, x1, y1, xs, den;
    int nxt;
    x0 = pt_x[0]; y0 = pt_y[0]; x1 = pt_x[1]; y1 = pt_y[1];
    nxt = 2;
    for (int k = 0; k < SAMPLES; k++) begin
      xs = longint'(k) * 32768;
      while (xs > x1 * SPAN && nxt < SAMPLES) begin
        x0 = x1; y0 = y1;
        x1 = pt_x[nxt]; y1 = pt_y[nxt];
        nxt++;
      end
      den = (x0 - x1) * SPAN;
      if (den == 0) grid[k] = clip17(y1);
      else grid[k] = clip17(y1 + rdiv((y0 - y1) * (xs - x1 * SPAN), den));
    end
  endfunction

  // Apply one accepted transaction; queries add one expected answer.
  function automatic void predict_curve(txn_t t);
    answer_t a;
    longint sc, idx, fr, t0, t1, v;
    if (t.mode == MODE_LOAD) begin
      if (n_loaded == 0) built = 1'b0;
      pt_x[n_loaded] = t.sx;
      pt_y[n_loaded] = longint'($signed(t.sy));
      n_loaded++;
      if (n_loaded >= SAMPLES) begin
        resample_grid();
        built = 1'b1;
        n_loaded = 0;
      end
      return;
    end
    if (!built) begin
      a.value = '0;
      a.table_ready = 1'b0;
    end else begin
      sc = longint'(t.qx) * SPAN;
      idx = sc / 32768;
      if (idx >= SPAN) v = grid[SPAN];
      else begin
        fr = sc - idx * 32768;
        t0 = grid[idx]; t1 = grid[idx + 1];
        v = clip17(t0 + fdiv((t1 - t0) * fr + 16384, 32768));
      end
      a.value = v[16:0];
      a.table_ready = 1'b1;
    end
    answer_q = {answer_q, a};
  endfunction

  function automatic txn_t mk_query(logic [15:0] qx);
    txn_t t;
    t.mode = MODE_QUERY; t.qx = qx;
    t.sx = 16'($urandom); t.sy = 17'($urandom);
    return t;
  endfunction

  function automatic txn_t mk_load(logic [15:0] sx, logic [16:0] sy);
    txn_t t;
    t.mode = MODE_LOAD; t.sx = sx; t.sy = sy; t.qx = 16'($urandom);
    return t;
  endfunction

  // Queue one full point set; style picks monotone, shuffled, two-level step or wild x.
  task automatic queue_curve(int style);
    int x;
    logic [15:0] sx;
    logic [16:0] sy;
    x = $urandom_range(0, 2000);
    for (int i = 0; i < SAMPLES; i++) begin
      case (style)
        0: begin
          x += $urandom_range(0, 1100);
          sx = (x > 32768) ? 16'd32768 : 16'(x);
        end
        1: sx = 16'($urandom_range(0, 32768));
        2: sx = (i < 32) ? 16'd0 : 16'd32768;
        default: sx = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: sy = 17'h10000;
        1: sy = 17'h0FFFF;
        default: sy = 17'($urandom);
      endcase
      add_pending(mk_load(sx, sy));
    end
  endtask

  initial begin
    int n_items;
    // directed: queries before any table, then an edge set and edge queries
    add_pending(mk_query(16'd0));
    add_pending(mk_query(16'hFFFF));
    queue_curve(2);
    add_pending(mk_query(16'd0));
    add_pending(mk_query(16'd16384));
    add_pending(mk_query(16'd32767));
    add_pending(mk_query(16'd32768));
    add_pending(mk_query(16'hFFFF));
    queue_curve(0);
    add_pending(mk_query(16'd520));
    add_pending(mk_query(16'd32768));
    // random: mostly whole sets followed by query bursts, some stray loads
    n_items = 0;
    while (n_items < 1000) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin queue_curve($urandom_range(0, 3)); n_items += SAMPLES; end
        4: begin
          add_pending(mk_load(16'($urandom), 17'($urandom)));
          n_items++;
        end
        default: begin
          for (int j = $urandom_range(1, 40); j > 0; j--) begin
            add_pending(mk_query($urandom_range(0, 3) == 0 ?
                        16'($urandom) : 16'($urandom_range(0, 32768))));
            n_items++;
          end
        end
      endcase
    end
    repeat (12) @(posedge clk);
    @(negedge clk) rst = 1'b0;
  end

  // Driver: one transaction at a time, with a random gap before each.
  always @(negedge clk) begin
    if (!rst) begin
      if (push && !full_s) begin
        predict_curve(cur_t);
        void'(pending_q.pop_front());
        gap_in = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      end
      if (!(push && full_s)) begin
        if (gap_in > 0 || pending_q.size() == 0) begin
          push <= 1'b0;
          if (gap_in > 0) gap_in--;
          if (pending_q.size() == 0) stim_done = 1'b1;
        end else begin
          cur_t = pending_q[0];
          push <= 1'b1;
          mode <= cur_t.mode;
          sample_x <= cur_t.sx;
          sample_y <= cur_t.sy;
          query_x <= cur_t.qx;
        end
      end
    end
  end

  always @(posedge clk) full_s <= full;

  // Monitor: checks accepted result transactions, pop has its own random stall.
  always @(posedge clk) begin
    answer_t a;
    if (!rst && pop && !empty) begin
      if (answer_q.size() == 0) begin
        $error("result transaction with nothing expected");
        errors++;
      end else begin
        a = answer_q.pop_front();
        if (value !== a.value) begin
          $error("value: expected %0d actual %0d", $signed(a.value), value);
          errors++;
        end
        if (table_ready !== a.table_ready) begin
          $error("table_ready: expected %0b actual %0b", a.table_ready, table_ready);
          errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst) pop <= 1'b0;
    else if (pop && !empty_s) begin
      gap_out = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      pop <= (gap_out == 0);
    end else if (!pop) begin
      if (gap_out > 0) gap_out--;
      pop <= (gap_out == 0);
    end
  end

  always @(posedge clk) empty_s <= empty;

  initial begin
    wait (stim_done && answer_q.size() == 0);
    repeat (SAMPLES * (NW + 6) + 100) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule

### files.f
rtl/crv_pkg.sv
rtl/crv_ram.sv
rtl/crv_front.sv
rtl/crv_cmd_queue.sv
rtl/crv_back.sv
rtl/curve_resample_interpolator_unit.sv
verif/tb_top.sv
